// File: rtl/core/wmr_pkg.sv
`timescale 1ns / 1ps
// Package for the windowed median reporter core.
// Window geometry, field widths, reset report period, item kind codes and rank constants.
// No dependencies.
package wmr_pkg;

  localparam int WINDOW_SIZE = 16;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

  // Ranks (0-based) of the two middle values; equal for an odd window.
  localparam int K_LO = (WINDOW_SIZE - 1) / 2;
  localparam int K_HI = WINDOW_SIZE / 2;

  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd120;

  localparam logic FUNC_READING = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

endpackage

// File: rtl/core/windowed_median_reporter_core.sv
`timescale 1ns / 1ps
// Windowed median reporter: reading ring in a synchronous memory, tick counter,
// and a rank-select sequencer that emits the window median on request.
// Depends on wmr_pkg.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, func, reading | sink
//   out     | out_valid, out_ready, median     | source
//   cfg     | cfg_valid, cfg_ready, cfg_data   | sink
//
// An item that raises no report leaves the core in S_IDLE, so in_ready stays high.
// During a report, for each stored entry the one memory read port sweeps the whole
// ring to rank it (S_RDC, S_LATC, S_SCAN, S_EVAL), then S_DONE loads the median.
// in_ready stays low during the sweep and while a finished median waits for a
// full output register; the output register takes out_ready independently.
// Synchronous reset clears control state; the ring is undefined until written.
module windowed_median_reporter_core
  import wmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [DATA_W-1:0] reading,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] median,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDC  = 3'd1;
  localparam logic [2:0] S_LATC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(WINDOW_SIZE);
  localparam logic [CNT_W:0]   RANK_LO  = (CNT_W + 1)'(K_LO);
  localparam logic [CNT_W:0]   RANK_HI  = (CNT_W + 1)'(K_HI);

  logic [DATA_W-1:0] mem [0:WINDOW_SIZE-1];
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [DATA_W-1:0] report_period;
  logic [IDX_W-1:0]  write_pos;
  logic              filled;
  logic [DATA_W-1:0] tick_count;
  logic              pending;

  logic [IDX_W-1:0]  cand_idx;
  logic [CNT_W-1:0]  scan_cnt;
  logic              data_vld;
  logic [DATA_W-1:0] cand;
  logic [CNT_W-1:0]  less;
  logic [CNT_W-1:0]  eq;
  logic [DATA_W-1:0] lo_val;
  logic [DATA_W-1:0] hi_val;

  logic              accept;
  logic              pending_next;
  logic              filled_next;
  logic [DATA_W:0]   tick_inc;
  logic [CNT_W:0]    rank_lt;
  logic [CNT_W:0]    rank_le;
  logic [DATA_W:0]   mid_sum;
  logic              out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (func == FUNC_READING);
  assign tick_inc  = {1'b0, tick_count} + {{DATA_W{1'b0}}, 1'b1};
  assign out_free  = !out_valid || out_ready;

  assign rd_en   = (state == S_RDC) || ((state == S_SCAN) && (scan_cnt < N_CNT));
  assign rd_addr = (state == S_RDC) ? cand_idx : scan_cnt[IDX_W-1:0];

  assign rank_lt = {1'b0, less};
  assign rank_le = {1'b0, less} + {1'b0, eq};
  assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};

  // Ring memory: one write port, one registered read port. The sweep only
  // starts the cycle after an item's write lands, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pos] <= reading;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    filled_next  = filled;
    pending_next = pending;
    if (accept) begin
      if (func == FUNC_READING) begin
        if (write_pos == LAST_IDX) begin
          filled_next = 1'b1;
        end
      end else if (tick_inc >= {1'b0, report_period}) begin
        pending_next = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && pending_next && filled_next) begin
          state_next = S_RDC;
        end
      end
      S_RDC:  state_next = S_LATC;
      S_LATC: state_next = S_SCAN;
      S_SCAN: begin
        if ((scan_cnt == N_CNT) && !data_vld) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: state_next = (cand_idx == LAST_IDX) ? S_DONE : S_RDC;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      report_period <= PERIOD_RESET;
      write_pos     <= '0;
      filled        <= 1'b0;
      tick_count    <= '0;
      pending       <= 1'b0;
      cand_idx      <= '0;
      scan_cnt      <= '0;
      data_vld      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        report_period <= cfg_data;
      end
      filled <= filled_next;
      // Drop the request once the sweep is launched.
      pending <= pending_next && !(state_next == S_RDC && state == S_IDLE);
      if (wr_en) begin
        write_pos <= (write_pos == LAST_IDX) ? '0 : write_pos + 1'b1;
      end
      if (accept && (func == FUNC_TICK)) begin
        tick_count <= (tick_inc >= {1'b0, report_period}) ? '0 : tick_inc[DATA_W-1:0];
      end
      if (state == S_IDLE) begin
        cand_idx <= '0;
      end else if (state == S_EVAL) begin
        cand_idx <= cand_idx + 1'b1;
      end
      if (state == S_LATC) begin
        scan_cnt <= '0;
        data_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        data_vld <= (scan_cnt < N_CNT);
        if (scan_cnt < N_CNT) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Rank datapath: count entries below and equal to the candidate, then keep
  // the candidate if its rank span covers a middle position.
  always_ff @(posedge clk) begin
    if (state == S_LATC) begin
      cand <= rd_data;
      less <= '0;
      eq   <= '0;
    end else if ((state == S_SCAN) && data_vld) begin
      if (rd_data < cand) begin
        less <= less + 1'b1;
      end else if (rd_data == cand) begin
        eq <= eq + 1'b1;
      end
    end
    if (state == S_EVAL) begin
      if ((rank_lt <= RANK_LO) && (RANK_LO < rank_le)) begin
        lo_val <= cand;
      end
      if ((rank_lt <= RANK_HI) && (RANK_HI < rank_le)) begin
        hi_val <= cand;
      end
    end
    if ((state == S_DONE) && out_free) begin
      median <= mid_sum[DATA_W:1];
    end
  end

  a_busy_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pending)
    else $error("report request still pending during median sweep");

  a_busy_filled: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> filled)
    else $error("median sweep started before the ring was filled");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (rank_le <= {1'b0, N_CNT}) && (rank_le != '0))
    else $error("candidate rank counts out of range");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> out_valid && (state == S_IDLE))
    else $error("finished median not loaded into output register");

endmodule
